@@ rtl/two_body_gravity_step_unit_assert.svh @@
// Assertion helpers for the gravity stepper.
`ifndef TWO_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH
`define TWO_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define TGS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tgs_pkg.sv @@
package tgs_pkg;

  localparam int unsigned WIDE = 128;
  localparam int unsigned HALF = 64;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_LOAD_FIRST  = 2'd1,
    CMD_LOAD_SECOND = 2'd2,
    CMD_UNUSED      = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    CFG_GRAV    = 3'd0,
    CFG_STEP    = 3'd1,
    CFG_MASS1   = 3'd2,
    CFG_MASS2   = 3'd3,
    CFG_CONTACT = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_D2,
    ST_U,
    ST_GM,
    ST_GT,
    ST_W,
    ST_DV,
    ST_POS,
    ST_OUT
  } state_t;

endpackage

@@ rtl/tgs_arith.sv @@
module tgs_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  tgs_pkg::arith_req_t           req,
  input  logic [tgs_pkg::WIDE-1:0]      opa,
  input  logic [tgs_pkg::WIDE-1:0]      opb,
  output logic                          done,
  output logic [tgs_pkg::WIDE-1:0]      result
);

  logic                          busy;
  tgs_pkg::arith_op_t            op_r;
  logic [6:0]                    cnt;
  logic [6:0]                    last_cnt;
  logic [tgs_pkg::WIDE-1:0]      a_r;
  logic [tgs_pkg::WIDE-1:0]      d_r;
  logic [tgs_pkg::WIDE-1:0]      nreg;
  logic [tgs_pkg::WIDE-1:0]      acc;
  logic [tgs_pkg::WIDE-1:0]      rmd;
  logic [65:0]                   rem;
  logic [tgs_pkg::HALF-1:0]      breg;
  logic                          ovf;

  logic [tgs_pkg::WIDE:0]        mul_sum;
  logic [tgs_pkg::WIDE:0]        div_try;
  logic [65:0]                   sq_shift;
  logic [65:0]                   sq_trial;

  always_comb begin
    unique case (op_r)
      tgs_pkg::OP_DIV: last_cnt = 7'd127;
      default:         last_cnt = 7'd63;
    endcase
  end

  always_comb begin
    mul_sum  = {acc, 1'b0} + {1'b0, (breg[tgs_pkg::HALF-1] ? a_r : '0)};
    div_try  = {rmd, nreg[tgs_pkg::WIDE-1]};
    sq_shift = {rem[63:0], nreg[tgs_pkg::WIDE-1 -: 2]};
    sq_trial = {acc[63:0], 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == last_cnt);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == last_cnt) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      cnt  <= '0;
      a_r  <= opa;
      d_r  <= opb;
      nreg <= opa;
      breg <= opb[tgs_pkg::HALF-1:0];
      acc  <= '0;
      rmd  <= '0;
      rem  <= '0;
      ovf  <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      unique case (op_r)
        tgs_pkg::OP_MUL: begin
          // MSB first: double and add, flag any bit lost off the top
          ovf  <= ovf | acc[tgs_pkg::WIDE-1] | mul_sum[tgs_pkg::WIDE];
          acc  <= mul_sum[tgs_pkg::WIDE-1:0];
          breg <= {breg[tgs_pkg::HALF-2:0], 1'b0};
        end
        tgs_pkg::OP_DIV: begin
          nreg <= {nreg[tgs_pkg::WIDE-2:0], 1'b0};
          if (div_try >= {1'b0, d_r}) begin
            rmd <= tgs_pkg::WIDE'(div_try - {1'b0, d_r});
            acc <= {acc[tgs_pkg::WIDE-2:0], 1'b1};
          end else begin
            rmd <= div_try[tgs_pkg::WIDE-1:0];
            acc <= {acc[tgs_pkg::WIDE-2:0], 1'b0};
          end
        end
        default: begin
          nreg <= {nreg[tgs_pkg::WIDE-3:0], 2'b00};
          if (sq_shift >= sq_trial) begin
            rem <= sq_shift - sq_trial;
            acc <= {acc[tgs_pkg::WIDE-2:0], 1'b1};
          end else begin
            rem <= sq_shift;
            acc <= {acc[tgs_pkg::WIDE-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      tgs_pkg::OP_MUL: result = ovf ? '1 : acc;
      tgs_pkg::OP_DIV: result = acc;
      default:         result = {{tgs_pkg::HALF{1'b0}}, acc[tgs_pkg::HALF-1:0]};
    endcase
  end

endmodule

@@ rtl/two_body_gravity_step_unit.sv @@
// Two-body gravity stepper, one semi-implicit Euler step per tick request.
// Input channel (in_valid/in_ready): command plus load fields. Command 1 or 2
// loads body one or two, command 0 advances one step, command 3 does nothing.
// Output channel (out_valid/out_ready): both positions and the moved flag,
// one result per input request, held until taken.
// Config channel (cfg_valid/cfg_ready): always ready, write while idle.
// Loads and unused commands go straight to the output. A tick runs a
// sequencer over one bit-serial unit (multiply, divide, square root):
// it stops after the distance when the bodies are in contact, and
// runs the full step otherwise.
// One request is in flight at a time; in_ready is low from acceptance until
// the result is taken, so a stalled receiver stalls the input.
// Reset (rst, synchronous) zeroes both bodies and restores the default
// register values.
module two_body_gravity_step_unit #(
  parameter int COORD_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic signed [COORD_WIDTH-1:0] load_pos_x,
  input  logic signed [COORD_WIDTH-1:0] load_pos_y,
  input  logic signed [COORD_WIDTH-1:0] load_pos_z,
  input  logic signed [COORD_WIDTH-1:0] load_vel_x,
  input  logic signed [COORD_WIDTH-1:0] load_vel_y,
  input  logic signed [COORD_WIDTH-1:0] load_vel_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] first_x,
  output logic signed [COORD_WIDTH-1:0] first_y,
  output logic signed [COORD_WIDTH-1:0] first_z,
  output logic signed [COORD_WIDTH-1:0] second_x,
  output logic signed [COORD_WIDTH-1:0] second_y,
  output logic signed [COORD_WIDTH-1:0] second_z,
  output logic                          moved,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [47:0]                   cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int W  = tgs_pkg::WIDE;
  localparam int H  = tgs_pkg::HALF;
  localparam logic signed [65:0] CMAX = (66'sd1 <<< (CW - 1)) - 66'sd1;
  localparam logic signed [65:0] CMIN = -(66'sd1 <<< (CW - 1));
  localparam int DV_SHIFT = 80 - FRACTION_BITS;

  tgs_pkg::state_t state, state_next;

  logic [31:0] grav_constant;
  logic [15:0] time_step;
  logic [31:0] mass_first;
  logic [31:0] mass_second;
  logic [47:0] contact_distance;

  logic signed [CW-1:0] pos [6];
  logic signed [CW-1:0] vel [6];
  logic [H-1:0]         mag [3];
  logic                 neg [3];
  logic [H-1:0]         u   [3];
  logic [W-1:0]         s;
  logic [H-1:0]         distance;
  logic [W-1:0]         dist2;
  logic [W-1:0]         c;
  logic [W-1:0]         w;
  logic [2:0]           idx;
  logic                 body;
  logic                 issued;

  tgs_pkg::arith_req_t  req;
  logic [W-1:0]         opa;
  logic [W-1:0]         opb;
  logic                 done;
  logic [W-1:0]         result;

  logic                 in_acc;
  logic [W:0]           s_sum;
  logic [2:0]           vsel;
  logic signed [CW:0]   vext;
  logic [H-1:0]         vm;
  logic [W-1:0]         dv;
  logic [H-1:0]         dm;
  logic                 dn;
  logic                 contact;
  logic signed [CW-1:0] lpos [3];
  logic signed [CW-1:0] lvel [3];

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] a,
                                                   input logic is_neg,
                                                   input logic [H-1:0] m);
    logic signed [65:0] ax;
    logic signed [65:0] mx;
    logic signed [65:0] room;
    ax = 66'(a);
    mx = $signed({2'b00, m});
    if (!is_neg) begin
      room = CMAX - ax;
      sat_add = (mx >= room) ? CW'(CMAX) : CW'(ax + mx);
    end else begin
      room = ax - CMIN;
      sat_add = (mx >= room) ? CW'(CMIN) : CW'(ax - mx);
    end
  endfunction

  assign lpos[0] = load_pos_x;
  assign lpos[1] = load_pos_y;
  assign lpos[2] = load_pos_z;
  assign lvel[0] = load_vel_x;
  assign lvel[1] = load_vel_y;
  assign lvel[2] = load_vel_z;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign contact   = (result[H-1:0] <= {16'd0, contact_distance});

  assign first_x  = pos[0];
  assign first_y  = pos[1];
  assign first_z  = pos[2];
  assign second_x = pos[3];
  assign second_y = pos[4];
  assign second_z = pos[5];

  always_comb begin
    s_sum = {1'b0, s} + {1'b0, result};
    vsel  = body ? (idx + 3'd3) : idx;
    vext  = (CW + 1)'(vel[idx]);
    vm    = H'(vext < 0 ? -vext : vext);
    dv    = result >> DV_SHIFT;
    dm    = (|dv[W-1:H]) ? '1 : dv[H-1:0];
    dn    = body ? !neg[idx[1:0]] : neg[idx[1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tgs_pkg::ST_IDLE:
        if (in_valid) begin
          state_next = (command == tgs_pkg::CMD_TICK) ? tgs_pkg::ST_SQ : tgs_pkg::ST_OUT;
        end
      tgs_pkg::ST_SQ:
        if (done && idx == 3'd2) state_next = tgs_pkg::ST_SQRT;
      tgs_pkg::ST_SQRT:
        if (done) state_next = contact ? tgs_pkg::ST_OUT : tgs_pkg::ST_D2;
      tgs_pkg::ST_D2:
        if (done) state_next = tgs_pkg::ST_U;
      tgs_pkg::ST_U:
        if (done && idx == 3'd2) state_next = tgs_pkg::ST_GM;
      tgs_pkg::ST_GM:
        if (done) state_next = tgs_pkg::ST_GT;
      tgs_pkg::ST_GT:
        if (done) state_next = tgs_pkg::ST_W;
      tgs_pkg::ST_W:
        if (done) state_next = tgs_pkg::ST_DV;
      tgs_pkg::ST_DV:
        if (done && idx == 3'd2) state_next = body ? tgs_pkg::ST_POS : tgs_pkg::ST_GM;
      tgs_pkg::ST_POS:
        if (done && idx == 3'd5) state_next = tgs_pkg::ST_OUT;
      tgs_pkg::ST_OUT:
        if (out_ready) state_next = tgs_pkg::ST_IDLE;
      default:
        state_next = tgs_pkg::ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    req.start = 1'b0;
    req.op    = tgs_pkg::OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      tgs_pkg::ST_IDLE: in_ready = 1'b1;
      tgs_pkg::ST_OUT:  out_valid = 1'b1;
      tgs_pkg::ST_SQ: begin
        opa = W'(mag[idx[1:0]]);
        opb = W'(mag[idx[1:0]]);
      end
      tgs_pkg::ST_SQRT: begin
        req.op = tgs_pkg::OP_SQRT;
        opa    = s;
      end
      tgs_pkg::ST_D2: begin
        opa = W'(distance);
        opb = W'(distance);
      end
      tgs_pkg::ST_U: begin
        req.op = tgs_pkg::OP_DIV;
        opa    = {32'd0, mag[idx[1:0]], 32'd0};
        opb    = W'(distance);
      end
      tgs_pkg::ST_GM: begin
        opa = W'(grav_constant);
        opb = W'(body ? mass_first : mass_second);
      end
      tgs_pkg::ST_GT: begin
        opa = c;
        opb = W'(time_step);
      end
      tgs_pkg::ST_W: begin
        req.op = tgs_pkg::OP_DIV;
        opa    = c << (2 * FRACTION_BITS);
        opb    = dist2;
      end
      tgs_pkg::ST_DV: begin
        opa = w;
        opb = W'(u[idx[1:0]]);
      end
      tgs_pkg::ST_POS: begin
        opa = W'(vm);
        opb = W'(time_step);
      end
      default: ;
    endcase
    if (state != tgs_pkg::ST_IDLE && state != tgs_pkg::ST_OUT) begin
      req.start = !issued;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= tgs_pkg::ST_IDLE;
      issued           <= 1'b0;
      idx              <= '0;
      body             <= 1'b0;
      moved            <= 1'b0;
      grav_constant    <= 32'd8388608;
      time_step        <= 16'd6554;
      mass_first       <= 32'd5120000;
      mass_second      <= 32'd2560;
      contact_distance <= 48'd1146880;
      for (int i = 0; i < 6; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (req.start) begin
        issued <= 1'b1;
      end else if (done) begin
        issued <= 1'b0;
      end

      if (cfg_valid) begin
        unique case (cfg_index)
          tgs_pkg::CFG_GRAV:    grav_constant    <= cfg_data[31:0];
          tgs_pkg::CFG_STEP:    time_step        <= cfg_data[15:0];
          tgs_pkg::CFG_MASS1:   mass_first       <= cfg_data[31:0];
          tgs_pkg::CFG_MASS2:   mass_second      <= cfg_data[31:0];
          tgs_pkg::CFG_CONTACT: contact_distance <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc) begin
        moved <= 1'b0;
        idx   <= '0;
        body  <= 1'b0;
        s     <= '0;
        for (int i = 0; i < 3; i++) begin
          if (command == tgs_pkg::CMD_LOAD_FIRST) begin
            pos[i] <= lpos[i];
            vel[i] <= lvel[i];
          end else if (command == tgs_pkg::CMD_LOAD_SECOND) begin
            pos[i + 3] <= lpos[i];
            vel[i + 3] <= lvel[i];
          end
        end
        for (int i = 0; i < 3; i++) begin
          logic signed [CW:0] diff;
          logic [CW:0]        absd;
          diff   = (CW + 1)'(pos[i + 3]) - (CW + 1)'(pos[i]);
          absd   = diff < 0 ? -diff : diff;
          neg[i] <= diff < 0;
          mag[i] <= H'(absd);
        end
      end

      if (done) begin
        unique case (state)
          tgs_pkg::ST_SQ: begin
            s   <= s_sum[W] ? '1 : s_sum[W-1:0];
            idx <= (idx == 3'd2) ? 3'd0 : idx + 3'd1;
          end
          tgs_pkg::ST_SQRT: distance <= result[H-1:0];
          tgs_pkg::ST_D2:   dist2 <= result;
          tgs_pkg::ST_U: begin
            u[idx[1:0]] <= result[H-1:0];
            idx         <= (idx == 3'd2) ? 3'd0 : idx + 3'd1;
          end
          tgs_pkg::ST_GM: c <= result;
          tgs_pkg::ST_GT: c <= result;
          tgs_pkg::ST_W:  w <= result;
          tgs_pkg::ST_DV: begin
            vel[vsel] <= sat_add(vel[vsel], dn, dm);
            if (idx == 3'd2) begin
              idx  <= 3'd0;
              body <= 1'b1;
            end else begin
              idx <= idx + 3'd1;
            end
          end
          tgs_pkg::ST_POS: begin
            pos[idx] <= sat_add(pos[idx], vext < 0, result[79:16]);
            if (idx == 3'd5) begin
              idx   <= 3'd0;
              moved <= 1'b1;
            end else begin
              idx <= idx + 3'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  tgs_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (done),
    .result (result)
  );

`include "two_body_gravity_step_unit_assert.svh"

  `TGS_ASSERT_IMPL(a_one_in_flight, in_ready, !out_valid, "input taken while result pending")
  `TGS_ASSERT_IMPL(a_done_in_compute,
    done, state != tgs_pkg::ST_IDLE && state != tgs_pkg::ST_OUT, "unit done outside a step")
  `TGS_ASSERT_NEXT(a_contact_freeze,
    state == tgs_pkg::ST_SQRT && done && contact,
    state == tgs_pkg::ST_OUT && !moved, "contact did not freeze motion")

endmodule
